FILE: hdl/ptt_pkg.sv
// Shared types and constants for the periodic timer table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ptt_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int ACTION_W   = 2;
  localparam int TICK_W     = 64;
  localparam int INTERVAL_W = 32;
  localparam int ID_W       = 16;
  localparam int EVENT_W    = 3;

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;

  typedef enum logic [EVENT_W-1:0] {
    EV_ADDED    = 3'd0,
    EV_REMOVED  = 3'd1,
    EV_NOTFOUND = 3'd2,
    EV_FIRED    = 3'd3,
    EV_FULL     = 3'd4,
    EV_DONE     = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_NEXT,
    ID_REQ,
    ID_SLOT
  } id_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [INTERVAL_W-1:0] interval;
    logic [TICK_W-1:0]     deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    in_ready;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    add_wr;
    logic    rm_clr;
    logic    fire_wr;
    logic    push;
    ev_t     ev;
    id_sel_t id_sel;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic                in_valid;
    logic [ACTION_W-1:0] in_action;
    logic [ACTION_W-1:0] action;
    logic                slot_valid;
    logic                idx_last;
    logic                id_match;
    logic                due;
    logic                out_free;
  } stat_t;

endpackage

FILE: hdl/ptt_in_if.sv
// Request channel of the periodic timer table.
// Depends on ptt_pkg for field widths.
interface ptt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::ACTION_W-1:0]   action;
  logic [ptt_pkg::TICK_W-1:0]     now;
  logic [ptt_pkg::INTERVAL_W-1:0] interval;
  logic [ptt_pkg::ID_W-1:0]       timer_id;

  modport source (output valid, action, now, interval, timer_id, input ready);
  modport sink (input valid, action, now, interval, timer_id, output ready);
endinterface

FILE: hdl/ptt_out_if.sv
// Result channel of the periodic timer table.
// Depends on ptt_pkg for field widths.
interface ptt_out_if;
  logic                       valid;
  logic                       ready;
  logic [ptt_pkg::EVENT_W-1:0] event_res;
  logic [ptt_pkg::ID_W-1:0]    timer_id_res;
  logic                       last;

  modport source (output valid, event_res, timer_id_res, last, input ready);
  modport sink (input valid, event_res, timer_id_res, last, output ready);
endinterface

FILE: hdl/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                    wr_data,
  input  logic                                rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/ptt_ctrl.sv
// Controller state machine of the periodic timer table.
// Depends on ptt_pkg; drives the datapath through cmd_t and watches stat_t.
module ptt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  ptt_pkg::stat_t st,
  output ptt_pkg::cmd_t  cmd
);

  ptt_pkg::state_t state_r, state_nxt;
  ptt_pkg::ev_t    final_ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    priority if (st.action == ptt_pkg::ACT_ADD) begin
      final_ev = ptt_pkg::EV_FULL;
    end else if (st.action == ptt_pkg::ACT_REMOVE) begin
      final_ev = ptt_pkg::EV_NOTFOUND;
    end else begin
      final_ev = ptt_pkg::EV_DONE;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.ev     = ptt_pkg::EV_DONE;
    cmd.id_sel = ptt_pkg::ID_ZERO;
    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.idx_clr  = 1'b1;
        if (st.in_valid && (st.in_action == ptt_pkg::ACT_ADD ||
                            st.in_action == ptt_pkg::ACT_REMOVE ||
                            st.in_action == ptt_pkg::ACT_CHECK)) begin
          state_nxt = ptt_pkg::ST_SCAN;
        end
      end
      ptt_pkg::ST_SCAN: begin
        if (st.action == ptt_pkg::ACT_ADD && !st.slot_valid) begin
          if (st.out_free) begin
            cmd.add_wr = 1'b1;
            cmd.push   = 1'b1;
            cmd.ev     = ptt_pkg::EV_ADDED;
            cmd.id_sel = ptt_pkg::ID_NEXT;
            cmd.last   = 1'b1;
            state_nxt  = ptt_pkg::ST_IDLE;
          end
        end else if (st.action != ptt_pkg::ACT_ADD && st.slot_valid) begin
          cmd.rd_en = 1'b1;
          state_nxt = ptt_pkg::ST_EVAL;
        end else if (st.idx_last) begin
          state_nxt = ptt_pkg::ST_FINAL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ptt_pkg::ST_EVAL: begin
        if (st.action == ptt_pkg::ACT_REMOVE && st.id_match) begin
          if (st.out_free) begin
            cmd.rm_clr = 1'b1;
            cmd.push   = 1'b1;
            cmd.ev     = ptt_pkg::EV_REMOVED;
            cmd.id_sel = ptt_pkg::ID_REQ;
            cmd.last   = 1'b1;
            state_nxt  = ptt_pkg::ST_IDLE;
          end
        end else if (st.action == ptt_pkg::ACT_CHECK && st.due && !st.out_free) begin
          state_nxt = ptt_pkg::ST_EVAL;
        end else begin
          if (st.action == ptt_pkg::ACT_CHECK && st.due) begin
            cmd.fire_wr = 1'b1;
            cmd.push    = 1'b1;
            cmd.ev      = ptt_pkg::EV_FIRED;
            cmd.id_sel  = ptt_pkg::ID_SLOT;
          end
          if (st.idx_last) begin
            state_nxt = ptt_pkg::ST_FINAL;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ptt_pkg::ST_SCAN;
          end
        end
      end
      ptt_pkg::ST_FINAL: begin
        if (st.out_free) begin
          cmd.push   = 1'b1;
          cmd.ev     = final_ev;
          cmd.id_sel = ptt_pkg::ID_ZERO;
          cmd.last   = 1'b1;
          state_nxt  = ptt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ptt_dp.sv
// Datapath of the periodic timer table: request latch, slot index, valid bits,
// timer RAM, deadline arithmetic and result register. Depends on ptt_pkg and ptt_ram.
module ptt_dp #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ptt_in_if.sink         in_ch,
  ptt_out_if.source      out_ch,
  input  ptt_pkg::cmd_t  cmd,
  output ptt_pkg::stat_t st
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ptt_pkg::ACTION_W-1:0]   act_r;
  logic [ptt_pkg::TICK_W-1:0]     now_r;
  logic [ptt_pkg::INTERVAL_W-1:0] ivl_r;
  logic [ptt_pkg::ID_W-1:0]       rid_r;

  logic [IW-1:0]             idx_r, idx_nxt;
  logic [SLOTS-1:0]          valid_r, valid_nxt;
  logic [ptt_pkg::ID_W-1:0]  next_id_r, next_id_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ptt_pkg::EVENT_W-1:0] out_ev_r;
  logic [ptt_pkg::ID_W-1:0]    out_id_r;
  logic                        out_last_r;
  logic [ptt_pkg::ID_W-1:0]    id_mux;

  logic                   accept;
  logic                   wr_en;
  ptt_pkg::entry_t        wr_entry;
  ptt_pkg::entry_t        rd_entry;
  logic [ptt_pkg::ENTRY_W-1:0] rd_raw;

  assign in_ch.ready  = cmd.in_ready && rst_n;
  assign accept       = in_ch.ready && in_ch.valid;

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_ch.action;
      now_r <= in_ch.now;
      ivl_r <= in_ch.interval;
      rid_r <= in_ch.timer_id;
    end
  end

  ptt_ram #(
    .WIDTH (ptt_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_raw)
  );

  assign rd_entry = ptt_pkg::entry_t'(rd_raw);
  assign wr_en    = cmd.add_wr || cmd.fire_wr;

  always_comb begin
    if (cmd.add_wr) begin
      wr_entry.id       = next_id_r;
      wr_entry.interval = ivl_r;
      wr_entry.deadline = now_r + {{(ptt_pkg::TICK_W-ptt_pkg::INTERVAL_W){1'b0}}, ivl_r};
    end else begin
      wr_entry.id       = rd_entry.id;
      wr_entry.interval = rd_entry.interval;
      wr_entry.deadline = rd_entry.deadline +
                          {{(ptt_pkg::TICK_W-ptt_pkg::INTERVAL_W){1'b0}}, rd_entry.interval};
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.add_wr) begin
      valid_nxt[idx_r] = 1'b1;
    end
    if (cmd.rm_clr) begin
      valid_nxt[idx_r] = 1'b0;
    end
    next_id_nxt = cmd.add_wr ? next_id_r + 1'b1 : next_id_r;
    priority if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_comb begin
    unique case (cmd.id_sel)
      ptt_pkg::ID_ZERO: id_mux = '0;
      ptt_pkg::ID_NEXT: id_mux = next_id_r;
      ptt_pkg::ID_REQ:  id_mux = rid_r;
      ptt_pkg::ID_SLOT: id_mux = rd_entry.id;
      default:          id_mux = '0;
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      valid_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_ev_r   <= cmd.ev;
      out_id_r   <= id_mux;
      out_last_r <= cmd.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = out_ev_r;
  assign out_ch.timer_id_res = out_id_r;
  assign out_ch.last         = out_last_r;

  assign st.in_valid   = in_ch.valid;
  assign st.in_action  = in_ch.action;
  assign st.action     = act_r;
  assign st.slot_valid = valid_r[idx_r];
  assign st.idx_last   = (idx_r == IW'(SLOTS - 1));
  assign st.id_match   = (rd_entry.id == rid_r);
  assign st.due        = (now_r >= rd_entry.deadline);
  assign st.out_free   = !out_valid_r || out_ch.ready;

endmodule

FILE: hdl/periodic_timer_table_core.sv
// Top level of the periodic timer table: controller plus datapath.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if, ptt_ctrl and ptt_dp.
//
// Requests arrive on in_ch (valid/ready): add, remove or check, with the
// current tick, an interval and a timer id. Results leave on out_ch, each
// with an event code, a timer id and a last flag on the final result of a
// request. Unused action codes are accepted and give no result.
// One request is handled at a time. An add walks the valid bits one slot a
// cycle. A remove or a check walks the slots, reads each occupied slot from
// the RAM in ST_SCAN, then compares it in ST_EVAL, where a check writes a
// fired timer back with its next deadline.
// A finished result sits in an output register, so a new request is taken
// while it waits. When the receiver stalls, the walk pauses at the slot that
// has a result to give and resumes once the register frees.
// Reset (rst_n, synchronous) clears all valid bits, the id counter and the
// output valid flag; a request is accepted once rst_n is high again.
module periodic_timer_table_core #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ptt_in_if.sink    in_ch,
  ptt_out_if.source out_ch
);

  ptt_pkg::cmd_t  cmd;
  ptt_pkg::stat_t st;

  ptt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  ptt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .st     (st)
  );

endmodule
